// ----- design/esd_pkg.sv -----
// ----------------------------------------------------------------------------
// esd_pkg
// shared types and constants of the escape sequence string decoder
// ----------------------------------------------------------------------------
package esd_pkg;

  localparam int MAX_STRING_LEN_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF    = 4;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 13;

  localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

  // one result as the front classifies it
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
  } res_t;

  // queue word: one or two results caused by one input byte
  typedef struct packed {
    logic two;
    res_t res0;
    res_t res1;
  } entry_t;

endpackage

// ----- design/esd_in_if.sv -----
// ----------------------------------------------------------------------------
// esd_in_if
// raw character channel of the escape sequence string decoder
// ----------------------------------------------------------------------------
interface esd_in_if;
  logic                      valid;
  logic                      ready;
  logic [esd_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- design/esd_out_if.sv -----
// ----------------------------------------------------------------------------
// esd_out_if
// decoded result channel of the escape sequence string decoder
// ----------------------------------------------------------------------------
interface esd_out_if;
  logic                        valid;
  logic                        ready;
  logic [esd_pkg::BYTE_W-1:0]  out_byte;
  logic [esd_pkg::KIND_W-1:0]  kind;
  logic [esd_pkg::COUNT_W-1:0] byte_count;
  logic                        last;

  modport source (output valid, output out_byte, output kind, output byte_count,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input byte_count,
                  input last, output ready);
endinterface

// ----- design/esd_front.sv -----
// ----------------------------------------------------------------------------
// esd_front
// accepts raw characters, tracks the escape mode and classifies results
// ----------------------------------------------------------------------------
module esd_front (
  input  logic            clk,
  input  logic            rst_n,
  esd_in_if.sink          in_chan,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic            q_full,
  output logic            q_push,
  output esd_pkg::entry_t q_wdata
);

  typedef enum logic [4:0] {
    MODE_GROUND = 5'b00001,
    MODE_ESC    = 5'b00010,
    MODE_OCT    = 5'b00100,
    MODE_HEX    = 5'b01000,
    MODE_CTRL   = 5'b10000
  } mode_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CTRL_MASK = 8'o037;

  function automatic logic [7:0] named_escape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h61:   r = 8'd7;
      8'h62:   r = 8'd8;
      8'h65:   r = CH_ESC;
      8'h66:   r = 8'd12;
      8'h6E:   r = 8'd10;
      8'h72:   r = 8'd13;
      8'h74:   r = 8'd9;
      8'h76:   r = 8'd11;
      CH_QUEST: r = CH_DEL;
      8'h5F:   r = 8'd32;
      default: r = c;
    endcase
    return r;
  endfunction

  mode_t           mode_r, mode_nxt;
  logic [7:0]      pend_r, pend_nxt;
  logic            eq_r;
  logic [7:0]      c;
  logic            accept;

  mode_t           g_mode;
  logic            g_has;
  esd_pkg::res_t   g_res;
  logic            hex_ok;
  logic [3:0]      hex_val;
  logic            has;
  esd_pkg::entry_t ent;

  assign c              = in_chan.in_byte;
  assign in_chan.ready  = !q_full;
  assign accept         = in_chan.valid && !q_full;

  // ground-state handling of a byte, shared by the number close path
  always_comb begin
    g_mode     = MODE_GROUND;
    g_has      = 1'b1;
    g_res.kind = esd_pkg::KIND_DATA;
    g_res.data = c;
    if (c == CH_COLON || c == CH_NUL || (c == CH_EQ && eq_r)) begin
      g_res.kind = esd_pkg::KIND_OK;
      g_res.data = '0;
    end else if (c == CH_BSL) begin
      g_mode = MODE_ESC;
      g_has  = 1'b0;
    end else if (c == CH_CARET) begin
      g_mode = MODE_CTRL;
      g_has  = 1'b0;
    end
  end

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = c[3:0];
    if (c >= CH_0 && c <= CH_9) begin
      hex_val = c[3:0];
    end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
      hex_val = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    mode_nxt       = mode_r;
    pend_nxt       = pend_r;
    has            = 1'b0;
    ent.two        = 1'b0;
    ent.res0.kind  = esd_pkg::KIND_DATA;
    ent.res0.data  = '0;
    ent.res1       = g_res;
    unique case (mode_r)
      MODE_ESC: begin
        if (c >= CH_0 && c <= CH_7) begin
          mode_nxt = MODE_OCT;
          pend_nxt = {5'b0, c[2:0]};
        end else if (c == CH_LX || c == CH_UX) begin
          mode_nxt = MODE_HEX;
          pend_nxt = '0;
        end else if (c == CH_NUL) begin
          mode_nxt      = MODE_GROUND;
          pend_nxt      = '0;
          has           = 1'b1;
          ent.res0.kind = esd_pkg::KIND_ERR;
        end else begin
          mode_nxt      = MODE_GROUND;
          has           = 1'b1;
          ent.res0.data = named_escape(c);
        end
      end
      MODE_OCT: begin
        if (c >= CH_0 && c <= CH_7) begin
          pend_nxt = {pend_r[4:0], c[2:0]};
        end else begin
          // flush the pending value, then treat the byte in ground state
          has           = 1'b1;
          ent.res0.data = pend_r;
          ent.two       = g_has;
          pend_nxt      = '0;
          mode_nxt      = g_mode;
        end
      end
      MODE_HEX: begin
        if (hex_ok) begin
          pend_nxt = {pend_r[3:0], hex_val};
        end else begin
          has           = 1'b1;
          ent.res0.data = pend_r;
          ent.two       = g_has;
          pend_nxt      = '0;
          mode_nxt      = g_mode;
        end
      end
      MODE_CTRL: begin
        mode_nxt = MODE_GROUND;
        has      = 1'b1;
        if (c >= CH_AT && c <= CH_TILDE) begin
          ent.res0.data = c & CTRL_MASK;
        end else if (c == CH_QUEST) begin
          ent.res0.data = CH_DEL;
        end else begin
          ent.res0.kind = esd_pkg::KIND_ERR;
          pend_nxt      = '0;
        end
      end
      default: begin
        mode_nxt = g_mode;
        has      = g_has;
        ent.res0 = g_res;
      end
    endcase
  end

  assign q_push  = accept && has;
  assign q_wdata = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GROUND;
      pend_r <= '0;
      eq_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        eq_r <= cfg_wdata;
      end
      if (accept) begin
        mode_r <= mode_nxt;
        pend_r <= pend_nxt;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // pending value is only carried while a number is open
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_GROUND || mode_r == MODE_CTRL || mode_r == MODE_ESC) |-> pend_r == '0)
    else $error("pending value left over outside number mode");
`endif

endmodule

// ----- design/esd_queue.sv -----
// ----------------------------------------------------------------------------
// esd_queue
// short fifo of classified words between front and back
// ----------------------------------------------------------------------------
module esd_queue #(
  parameter int DEPTH = esd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  esd_pkg::entry_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output logic            rd_valid,
  output esd_pkg::entry_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  esd_pkg::entry_t    mem_r [DEPTH];
  logic [PTR_W-1:0]   wp_r, rp_r;
  logic [CNT_W-1:0]   cnt_r;

  assign full     = (cnt_r == CNT_FULL);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !wr_en)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !rd_valid |-> !rd_en)
    else $error("queue read while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue count out of range");
`endif

endmodule

// ----- design/esd_back.sv -----
// ----------------------------------------------------------------------------
// esd_back
// expands queued words into results, keeps the byte count, drives output
// ----------------------------------------------------------------------------
module esd_back #(
  parameter int MAX_STRING_LEN = esd_pkg::MAX_STRING_LEN_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  esd_pkg::entry_t q_head,
  output logic            q_pop,
  esd_out_if.source       out_chan
);

  localparam int CNT_W = $clog2(MAX_STRING_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_STRING_LEN);

  logic                        idx_r;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        ov_r;
  logic [esd_pkg::BYTE_W-1:0]  obyte_r;
  logic [esd_pkg::KIND_W-1:0]  okind_r;
  logic [esd_pkg::COUNT_W-1:0] ocnt_r, ocnt_nxt;
  logic                        olast_r;

  esd_pkg::res_t               cur;
  logic                        cur_last;
  logic                        load;
  logic [CNT_W+esd_pkg::COUNT_W-1:0] cnt_ext;

  assign cur      = idx_r ? q_head.res1 : q_head.res0;
  assign cur_last = idx_r || !q_head.two;
  assign load     = q_valid && (!ov_r || out_chan.ready);
  assign q_pop    = load && cur_last;

  always_comb begin
    if (cur.kind == esd_pkg::KIND_DATA) begin
      cnt_nxt = (cnt_r < CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // low bits of the count as shown on the port
  assign cnt_ext  = {{esd_pkg::COUNT_W{1'b0}}, cnt_nxt};
  assign ocnt_nxt = cnt_ext[esd_pkg::COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (load) begin
      obyte_r <= cur.data;
      okind_r <= cur.kind;
      ocnt_r  <= ocnt_nxt;
      olast_r <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (load) begin
        ov_r  <= 1'b1;
        idx_r <= !cur_last;
        cnt_r <= (cur.kind == esd_pkg::KIND_DATA) ? cnt_nxt : '0;
      end else if (out_chan.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid      = ov_r;
  assign out_chan.out_byte   = obyte_r;
  assign out_chan.kind       = okind_r;
  assign out_chan.byte_count = ocnt_r;
  assign out_chan.last       = olast_r;

`ifndef NO_ASSERTIONS
  // second half of a word is only pending while that word is still queued
  a_idx_head: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r |-> q_valid)
    else $error("second result pending with empty queue");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (load && cur.kind != esd_pkg::KIND_DATA) |=> cnt_r == '0)
    else $error("count not cleared at end of string");
`endif

endmodule

// ----- design/escape_sequence_string_decoder_top.sv -----
// ----------------------------------------------------------------------------
// escape_sequence_string_decoder_top
// escaped string decoder: front classifier, word queue, result back end
// ----------------------------------------------------------------------------
// Takes one raw character per cycle while in_chan.ready is high and gives
// decoded bytes followed by one end word per string. A character that closes
// an open octal or hex number may give two words; the back end sends one word
// per cycle while out_chan.ready is high, and the QUEUE_DEPTH entry queue
// between the front and the back absorbs the extra word while in_chan.ready
// stays high. in_chan.ready drops only when the queue is full. An accepted
// character is written into the queue, then into the output register. The byte
// count saturates at MAX_STRING_LEN and shows its low 13 bits. cfg_wdata sets
// whether an unescaped '=' ends the string; write it while the block is idle.
module escape_sequence_string_decoder_top #(
  parameter int MAX_STRING_LEN = esd_pkg::MAX_STRING_LEN_DEF,
  parameter int QUEUE_DEPTH    = esd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  esd_in_if.sink     in_chan,
  esd_out_if.source  out_chan,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  esd_pkg::entry_t q_wdata;
  esd_pkg::entry_t q_head;

  esd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  esd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_data  (q_wdata),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_head)
  );

  esd_back #(
    .MAX_STRING_LEN (MAX_STRING_LEN)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

// ----- tb/escape_sequence_string_decoder_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_sequence_string_decoder_top_tb
// self-checking bench for the escaped string decoder
// ----------------------------------------------------------------------------
// Feeds raw characters through the input channel, predicts the decoded words
// with a behavioral decoder kept in step with every accepted character, and
// checks each output word in order. Covers backslash, octal, hex and caret
// escapes, terminators under both settings of the equals option and error
// ends, with random stalls on both sides.
// ----------------------------------------------------------------------------
module escape_sequence_string_decoder_top_tb;

  localparam int STR_LIMIT = esd_pkg::MAX_STRING_LEN_DEF;

  localparam logic [esd_pkg::BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [esd_pkg::BYTE_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [esd_pkg::BYTE_W-1:0] CH_EQUALS = 8'h3D;
  localparam logic [esd_pkg::BYTE_W-1:0] CH_QMARK  = 8'h3F;
  localparam logic [esd_pkg::BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [esd_pkg::BYTE_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [esd_pkg::BYTE_W-1:0] CTRL_MASK = 8'h1F;
  localparam logic [esd_pkg::BYTE_W-1:0] ESC_CHAR  = 8'h1B;
  localparam logic [esd_pkg::BYTE_W-1:0] DEL_CHAR  = 8'h7F;

  typedef enum logic [2:0] {
    ST_GROUND,
    ST_ESCAPE,
    ST_OCT,
    ST_HEX,
    ST_CTRL
  } dec_mode_t;

  typedef struct {
    logic [esd_pkg::BYTE_W-1:0]  data;
    logic [esd_pkg::KIND_W-1:0]  kind;
    logic [esd_pkg::COUNT_W-1:0] count;
    logic                        last;
  } word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  bit   calm;
  bit   failed;

  logic [esd_pkg::BYTE_W-1:0] raw_chars[$];
  word_t                      expected_words[$];

  // decoder state as predicted
  dec_mode_t                  dec_mode  = ST_GROUND;
  logic [esd_pkg::BYTE_W-1:0] num_acc   = '0;
  int                         str_count = 0;
  logic                       eq_ends   = 1'b0;

  esd_in_if  in_if();
  esd_out_if out_if();

  escape_sequence_string_decoder_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void emit_word(logic [esd_pkg::BYTE_W-1:0] b,
                                    logic [esd_pkg::KIND_W-1:0] k);
    word_t w;
    w.data  = (k == esd_pkg::KIND_DATA) ? b : '0;
    w.kind  = k;
    w.count = str_count[esd_pkg::COUNT_W-1:0];
    w.last  = 1'b0;
    expected_words.push_back(w);
  endfunction

  function automatic void emit_data(logic [esd_pkg::BYTE_W-1:0] b);
    if (str_count < STR_LIMIT) str_count++;
    emit_word(b, esd_pkg::KIND_DATA);
  endfunction

  function automatic void end_string(logic [esd_pkg::KIND_W-1:0] k);
    emit_word('0, k);
    dec_mode  = ST_GROUND;
    num_acc   = '0;
    str_count = 0;
  endfunction

  function automatic logic [esd_pkg::BYTE_W-1:0] named_char(logic [esd_pkg::BYTE_W-1:0] c);
    case (c)
      "a":      return 8'd7;
      "b":      return 8'd8;
      "e":      return ESC_CHAR;
      "f":      return 8'd12;
      "n":      return 8'd10;
      "r":      return 8'd13;
      "t":      return 8'd9;
      "v":      return 8'd11;
      CH_QMARK: return DEL_CHAR;
      "_":      return 8'h20;
      default:  return c;
    endcase
  endfunction

  function automatic void ground_char(logic [esd_pkg::BYTE_W-1:0] c);
    dec_mode = ST_GROUND;
    if (c == CH_COLON || c == CH_NUL) end_string(esd_pkg::KIND_OK);
    else if (c == CH_BSLASH) dec_mode = ST_ESCAPE;
    else if (c == CH_CARET) dec_mode = ST_CTRL;
    else if (c == CH_EQUALS && eq_ends) end_string(esd_pkg::KIND_OK);
    else emit_data(c);
  endfunction

  function automatic void decode_char(logic [esd_pkg::BYTE_W-1:0] c);
    int base_n;
    int digit;
    base_n = expected_words.size();
    digit  = -1;
    case (dec_mode)
      ST_ESCAPE: begin
        if (c >= "0" && c <= "7") begin
          dec_mode = ST_OCT;
          num_acc  = c - "0";
        end else if (c == "x" || c == "X") begin
          dec_mode = ST_HEX;
          num_acc  = '0;
        end else if (c == CH_NUL) begin
          end_string(esd_pkg::KIND_ERR);
        end else begin
          dec_mode = ST_GROUND;
          emit_data(named_char(c));
        end
      end
      ST_OCT: begin
        if (c >= "0" && c <= "7") begin
          num_acc = (num_acc << 3) + (c - "0");
        end else begin
          // non-digit closes the number, then gets handled from ground
          emit_data(num_acc);
          num_acc = '0;
          ground_char(c);
        end
      end
      ST_HEX: begin
        if (c >= "0" && c <= "9") digit = int'(c) - int'("0");
        else if (c >= "a" && c <= "f") digit = int'(c) - int'("a") + 10;
        else if (c >= "A" && c <= "F") digit = int'(c) - int'("A") + 10;
        if (digit >= 0) begin
          num_acc = (num_acc << 4) + digit[esd_pkg::BYTE_W-1:0];
        end else begin
          emit_data(num_acc);
          num_acc = '0;
          ground_char(c);
        end
      end
      ST_CTRL: begin
        dec_mode = ST_GROUND;
        if (c >= "@" && c <= "~") emit_data(c & CTRL_MASK);
        else if (c == CH_QMARK) emit_data(DEL_CHAR);
        else end_string(esd_pkg::KIND_ERR);
      end
      default: ground_char(c);
    endcase
    if (expected_words.size() > base_n)
      expected_words[expected_words.size()-1].last = 1'b1;
  endfunction

  // input driver: one word offered per cycle, held while stalled
  always @(posedge clk) begin
    logic stalled;
    stalled = in_if.valid && !in_if.ready;
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.in_byte <= '0;
    end else begin
      if (in_if.valid && in_if.ready) decode_char(in_if.in_byte);
      if (!stalled) begin
        if (raw_chars.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
          in_if.valid   <= 1'b1;
          in_if.in_byte <= raw_chars.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_if.ready <= rst_n && (calm || $urandom_range(99) >= 22);
  end

  // output monitor
  always @(posedge clk) begin
    word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: out_byte %0h kind %0d byte_count %0d last %0b",
               out_if.out_byte, out_if.kind, out_if.byte_count, out_if.last);
        failed = 1'b1;
      end else begin
        want = expected_words.pop_front();
        if (out_if.out_byte !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_if.out_byte);
          failed = 1'b1;
        end
        if (out_if.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_if.kind);
          failed = 1'b1;
        end
        if (out_if.byte_count !== want.count) begin
          $error("byte_count: expected %0d, got %0d", want.count, out_if.byte_count);
          failed = 1'b1;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_if.last);
          failed = 1'b1;
        end
      end
    end
  end

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) raw_chars.push_back(s[i]);
  endfunction

  function automatic logic [esd_pkg::BYTE_W-1:0] plain_char();
    logic [esd_pkg::BYTE_W-1:0] b;
    do begin
      b = esd_pkg::BYTE_W'($urandom_range(255));
    end while (b == CH_COLON || b == CH_NUL || b == CH_BSLASH || b == CH_CARET ||
               b == CH_EQUALS);
    return b;
  endfunction

  // one well-formed token with random content, or a random noise byte
  function automatic int queue_token();
    string named_keys;
    string hex_keys;
    int    pick;
    int    n;
    named_keys = "abefnrtv?_";
    hex_keys   = "0123456789abcdefABCDEF";
    pick       = $urandom_range(99);
    n          = raw_chars.size();
    if (pick < 30) begin
      raw_chars.push_back(plain_char());
    end else if (pick < 42) begin
      raw_chars.push_back(CH_BSLASH);
      if ($urandom_range(1)) raw_chars.push_back(named_keys[$urandom_range(9)]);
      else raw_chars.push_back(esd_pkg::BYTE_W'($urandom_range(255)));
    end else if (pick < 54) begin
      raw_chars.push_back(CH_BSLASH);
      repeat ($urandom_range(4, 1))
        raw_chars.push_back(esd_pkg::BYTE_W'(int'("0") + $urandom_range(7)));
    end else if (pick < 66) begin
      raw_chars.push_back(CH_BSLASH);
      raw_chars.push_back($urandom_range(1) ? "x" : "X");
      repeat ($urandom_range(3)) raw_chars.push_back(hex_keys[$urandom_range(21)]);
    end else if (pick < 78) begin
      raw_chars.push_back(CH_CARET);
      case ($urandom_range(2))
        0:       raw_chars.push_back(esd_pkg::BYTE_W'($urandom_range("~", "@")));
        1:       raw_chars.push_back(CH_QMARK);
        default: raw_chars.push_back(esd_pkg::BYTE_W'($urandom_range(255)));
      endcase
    end else if (pick < 88) begin
      case ($urandom_range(2))
        0:       raw_chars.push_back(CH_COLON);
        1:       raw_chars.push_back(CH_NUL);
        default: raw_chars.push_back(CH_EQUALS);
      endcase
    end else begin
      raw_chars.push_back(esd_pkg::BYTE_W'($urandom_range(255)));
    end
    return raw_chars.size() - n;
  endfunction

  task automatic drain();
    do @(posedge clk);
    while (raw_chars.size() != 0 || in_if.valid || expected_words.size() != 0);
    // characters that give no word may still be in the pipe
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(logic v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    eq_ends = v;
  endtask

  task automatic random_phase(int count);
    int done_n;
    done_n = 0;
    while (done_n < count) done_n += queue_token();
    drain();
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    calm          = 1'b0;
    failed        = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    write_cfg(1'b0);
    raw_chars.push_back(8'hFF);
    push_text("\\n\\3777:\\xAf1=^?^@^~^!");
    raw_chars.push_back(CH_BSLASH);
    raw_chars.push_back(CH_NUL);
    raw_chars.push_back(CH_NUL);
    drain();

    write_cfg(1'b1);
    push_text("a=\\X7=\\18\\5=b:");
    drain();

    random_phase(425);
    write_cfg(1'b0);
    random_phase(425);
    write_cfg(1'b1);
    calm = 1'b1;
    random_phase(425);
    calm = 1'b0;
    write_cfg(1'b0);
    random_phase(425);

    if (failed) begin
      $display("Test completed with failures");
    end else begin
      $display("Test completed successfully");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
